[hw/rtl/tdwg_pkg.sv]
// shared types, register map codes and sine table of the waveform generator
package tdwg_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_SQ_HALF   = 3'd1;
  localparam logic [2:0] REG_SINE_HOLD = 3'd2;
  localparam logic [2:0] REG_SQ_HIGH   = 3'd3;
  localparam logic [2:0] REG_SQ_LOW    = 3'd4;
  localparam logic [2:0] REG_TRI_STEP  = 3'd5;

  // waveform codes
  typedef enum logic [1:0] {
    MODE_SQUARE   = 2'd0,
    MODE_SINE     = 2'd1,
    MODE_TRIANGLE = 2'd2,
    MODE_OFF      = 2'd3
  } wave_mode_e;

  localparam int RomDepth = 128;
  localparam int DacBits  = 12;

  typedef logic [DacBits-1:0] dac_t;

  // one period from 0 to 3700 centered on 1850, unused tail reads as zero
  localparam dac_t SINE_ROM [RomDepth] = '{
    12'd1850, 12'd1966, 12'd2082, 12'd2197, 12'd2310, 12'd2422, 12'd2531, 12'd2638,
    12'd2741, 12'd2841, 12'd2937, 12'd3029, 12'd3116, 12'd3199, 12'd3275, 12'd3347,
    12'd3412, 12'd3471, 12'd3524, 12'd3570, 12'd3609, 12'd3642, 12'd3667, 12'd3685,
    12'd3696, 12'd3700, 12'd3696, 12'd3685, 12'd3667, 12'd3642, 12'd3609, 12'd3570,
    12'd3524, 12'd3471, 12'd3412, 12'd3347, 12'd3275, 12'd3199, 12'd3116, 12'd3029,
    12'd2937, 12'd2841, 12'd2741, 12'd2638, 12'd2531, 12'd2422, 12'd2310, 12'd2197,
    12'd2082, 12'd1966, 12'd1850, 12'd1734, 12'd1618, 12'd1503, 12'd1390, 12'd1278,
    12'd1169, 12'd1062, 12'd959,  12'd859,  12'd763,  12'd671,  12'd584,  12'd501,
    12'd425,  12'd353,  12'd288,  12'd229,  12'd176,  12'd130,  12'd91,   12'd58,
    12'd33,   12'd15,   12'd4,    12'd0,    12'd4,    12'd15,   12'd33,   12'd58,
    12'd91,   12'd130,  12'd176,  12'd229,  12'd288,  12'd353,  12'd425,  12'd501,
    12'd584,  12'd671,  12'd763,  12'd859,  12'd959,  12'd1062, 12'd1169, 12'd1278,
    12'd1390, 12'd1503, 12'd1618, 12'd1734, 12'd1850, 12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0
  };

endpackage

[hw/rtl/tick_driven_waveform_generator.sv]
// top level of the tick driven waveform generator
//
//  channel | signals                                   | direction | moves
//  --------+-------------------------------------------+-----------+-------------------------
//  in      | in_valid_i, in_ready_o, tick_i            | in        | one timer tick request
//  out     | out_valid_o, out_ready_i, dac_value_o     | out       | one dac sample request
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | in/out    | register write / read
//          | prdata, pready                            |           |
//
// one tick request is taken per cycle while in_ready_o is high; its sample (if any) is
// registered into the output register, or into the skid register behind a full one
// the rate is set by the single update of the counter / index registers per tick
// a two-entry output stage (output register plus skid register) keeps in_ready_o
// free of any combinational path from out_ready_i; input stalls only when both hold
// reset (asynchronous, active low) clears counters and output valids, sets the phase to
// rising and loads the register defaults; any write to the mode register also clears state
module tick_driven_waveform_generator #(
  parameter int TABLE_ENTRIES = 101,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  // sample channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] dac_value_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // index must hold TABLE_ENTRIES itself (sine index runs one past the end)
  localparam int IdxW  = $clog2(TABLE_ENTRIES + 1);
  localparam int ProdW = IdxW + 6;
  localparam logic [16:0] SampleMax = 17'((1 << SAMPLE_BITS) - 1);
  localparam logic [IdxW-1:0] IdxEnd  = IdxW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] IdxTurn = IdxW'(TABLE_ENTRIES - 2);

  // configuration registers
  logic [1:0]  mode_q;
  logic [7:0]  sq_half_q;
  logic [7:0]  sine_hold_q;
  logic [11:0] sq_high_q;
  logic [11:0] sq_low_q;
  logic [5:0]  tri_step_q;

  // waveform state
  logic [7:0]      tick_cnt_q, tick_cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            phase_up_q, phase_up_d;

  // output stage
  logic [11:0] out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  logic        cfg_wr;
  logic [2:0]  reg_sel;
  logic        tick_acc;
  logic        emit;
  logic [11:0] sample;
  logic        pop;

  logic [7:0]       idx_wide;
  logic [6:0]       rom_addr;
  logic [ProdW-1:0] tri_prod;
  logic [16:0]      tri_ext;
  logic [16:0]      tri_sat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  // register read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      tdwg_pkg::REG_MODE:      prdata = 32'(mode_q);
      tdwg_pkg::REG_SQ_HALF:   prdata = 32'(sq_half_q);
      tdwg_pkg::REG_SINE_HOLD: prdata = 32'(sine_hold_q);
      tdwg_pkg::REG_SQ_HIGH:   prdata = 32'(sq_high_q);
      tdwg_pkg::REG_SQ_LOW:    prdata = 32'(sq_low_q);
      tdwg_pkg::REG_TRI_STEP:  prdata = 32'(tri_step_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tdwg_pkg::MODE_SQUARE;
      sq_half_q   <= 8'd100;
      sine_hold_q <= 8'd1;
      sq_high_q   <= 12'd3700;
      sq_low_q    <= 12'd0;
      tri_step_q  <= 6'd37;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        tdwg_pkg::REG_MODE:      mode_q      <= pwdata[1:0];
        tdwg_pkg::REG_SQ_HALF:   sq_half_q   <= pwdata[7:0];
        tdwg_pkg::REG_SINE_HOLD: sine_hold_q <= pwdata[7:0];
        tdwg_pkg::REG_SQ_HIGH:   sq_high_q   <= pwdata[11:0];
        tdwg_pkg::REG_SQ_LOW:    sq_low_q    <= pwdata[11:0];
        tdwg_pkg::REG_TRI_STEP:  tri_step_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  assign tick_acc = in_valid_i & in_ready_o & tick_i;

  // sine lookup: past the last entry the table restarts at entry 0
  assign idx_wide = 8'(idx_q);
  assign rom_addr = (idx_q < IdxEnd) ? idx_wide[6:0] : 7'd0;

  // triangle sample with saturation to the sample range
  assign tri_prod = ProdW'(idx_q) * ProdW'(tri_step_q);
  assign tri_ext  = 17'(tri_prod);
  assign tri_sat  = (tri_ext > SampleMax) ? SampleMax : tri_ext;

  // one tick of waveform state update
  always_comb begin
    tick_cnt_d = tick_cnt_q;
    idx_d      = idx_q;
    phase_up_d = phase_up_q;
    emit       = 1'b0;
    sample     = '0;
    if (tick_acc) begin
      unique case (mode_q)
        tdwg_pkg::MODE_SQUARE: begin
          if (tick_cnt_q == sq_half_q) begin
            emit       = 1'b1;
            sample     = phase_up_q ? sq_low_q : sq_high_q;
            phase_up_d = ~phase_up_q;
            tick_cnt_d = '0;
          end else begin
            tick_cnt_d = tick_cnt_q + 8'd1;
          end
        end
        tdwg_pkg::MODE_SINE: begin
          if (tick_cnt_q == sine_hold_q) begin
            emit       = 1'b1;
            sample     = tdwg_pkg::SINE_ROM[rom_addr];
            tick_cnt_d = '0;
            idx_d      = (idx_q < IdxEnd) ? idx_q + IdxW'(1) : '0;
          end else begin
            tick_cnt_d = tick_cnt_q + 8'd1;
          end
        end
        tdwg_pkg::MODE_TRIANGLE: begin
          emit   = 1'b1;
          sample = tri_sat[11:0];
          if (phase_up_q) begin
            if (idx_q <= IdxTurn) idx_d = idx_q + IdxW'(1);
            else                  phase_up_d = 1'b0;
          end else begin
            if (idx_q != '0) begin
              idx_d = idx_q - IdxW'(1);
            end else begin
              phase_up_d = 1'b1;
              idx_d      = IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= '0;
      idx_q      <= '0;
      phase_up_q <= 1'b1;
    end else if (cfg_wr && reg_sel == tdwg_pkg::REG_MODE) begin
      tick_cnt_q <= '0;
      idx_q      <= '0;
      phase_up_q <= 1'b1;
    end else begin
      tick_cnt_q <= tick_cnt_d;
      idx_q      <= idx_d;
      phase_up_q <= phase_up_d;
    end
  end

  // output register with skid entry behind it
  assign pop        = out_valid_q & out_ready_i;
  assign in_ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= emit;
        end
      end else if (emit) begin
        if (!out_valid_q) out_valid_q  <= 1'b1;
        else              skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (emit && (pop || !out_valid_q)) begin
      out_q <= sample;
    end
    if (emit && out_valid_q && !pop) begin
      skid_q <= sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_value_o = out_q;

  // skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // after every triangle tick the output is valid on the next cycle
  a_tri_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && mode_q == tdwg_pkg::MODE_TRIANGLE) |=> out_valid_o)
    else $error("triangle tick produced no sample");

  // the table index never runs beyond one past the last entry
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxEnd)
    else $error("table index out of range");

endmodule

[verif/tdwg_checker.sv]
`timescale 1ns / 100ps
// checker for the waveform generator: predicts each dac sample and compares on the output
module tdwg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        tick_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [11:0] dac_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int TableEntries = 101;
  localparam int SampleMax    = (1 << tdwg_pkg::DacBits) - 1;

  // register copies
  tdwg_pkg::wave_mode_e mode_q;
  logic [7:0]           sq_half_q;
  logic [7:0]           sine_hold_q;
  tdwg_pkg::dac_t       sq_high_q;
  tdwg_pkg::dac_t       sq_low_q;
  logic [5:0]           tri_step_q;

  // waveform state
  logic [7:0]  tick_cnt_q;
  logic [6:0]  index_q;
  logic        rising_q;

  tdwg_pkg::dac_t samples_due[$];
  tdwg_pkg::dac_t predicted;
  tdwg_pkg::dac_t oldest;
  logic [31:0]    shadow;
  string          label;
  int             error_count = 0;

  assign fail_count_o = error_count;

  // one tick through the waveform state; returns 1 when a sample comes out
  function automatic bit advance_waveform(input logic tick, output tdwg_pkg::dac_t sample);
    logic [12:0] product;
    sample = '0;
    if (!tick) return 1'b0;
    case (mode_q)
      tdwg_pkg::MODE_SQUARE: begin
        if (tick_cnt_q != sq_half_q) begin
          tick_cnt_q = tick_cnt_q + 8'd1;
          return 1'b0;
        end
        sample     = rising_q ? sq_low_q : sq_high_q;
        rising_q   = !rising_q;
        tick_cnt_q = '0;
        return 1'b1;
      end
      tdwg_pkg::MODE_SINE: begin
        if (tick_cnt_q != sine_hold_q) begin
          tick_cnt_q = tick_cnt_q + 8'd1;
          return 1'b0;
        end
        tick_cnt_q = '0;
        if (index_q < TableEntries) begin
          sample  = tdwg_pkg::SINE_ROM[index_q];
          index_q = index_q + 7'd1;
        end else begin
          // past the last entry: entry 0 again without advancing
          index_q = '0;
          sample  = tdwg_pkg::SINE_ROM[0];
        end
        return 1'b1;
      end
      tdwg_pkg::MODE_TRIANGLE: begin
        product = index_q * tri_step_q;
        sample  = (product > SampleMax) ? tdwg_pkg::dac_t'(SampleMax) : product[11:0];
        if (rising_q) begin
          if (index_q <= TableEntries - 2) index_q = index_q + 7'd1;
          else rising_q = 1'b0;
        end else if (index_q != 0) begin
          index_q = index_q - 7'd1;
        end else begin
          rising_q = 1'b1;
          index_q  = 7'd1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mode_q      = tdwg_pkg::MODE_SQUARE;
      sq_half_q   = 8'd100;
      sine_hold_q = 8'd1;
      sq_high_q   = 12'd3700;
      sq_low_q    = 12'd0;
      tri_step_q  = 6'd37;
      tick_cnt_q  = '0;
      index_q     = '0;
      rising_q    = 1'b1;
      samples_due.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            tdwg_pkg::REG_MODE: begin
              mode_q     = tdwg_pkg::wave_mode_e'(pwdata[1:0]);
              tick_cnt_q = '0;
              index_q    = '0;
              rising_q   = 1'b1;
            end
            tdwg_pkg::REG_SQ_HALF:   sq_half_q   = pwdata[7:0];
            tdwg_pkg::REG_SINE_HOLD: sine_hold_q = pwdata[7:0];
            tdwg_pkg::REG_SQ_HIGH:   sq_high_q   = pwdata[11:0];
            tdwg_pkg::REG_SQ_LOW:    sq_low_q    = pwdata[11:0];
            tdwg_pkg::REG_TRI_STEP:  tri_step_q  = pwdata[5:0];
            default: ;
          endcase
        end else if (paddr[4:2] <= tdwg_pkg::REG_TRI_STEP) begin
          case (paddr[4:2])
            tdwg_pkg::REG_MODE: begin
              label  = "wave_mode";
              shadow = 32'(mode_q);
            end
            tdwg_pkg::REG_SQ_HALF: begin
              label  = "square_half_ticks";
              shadow = 32'(sq_half_q);
            end
            tdwg_pkg::REG_SINE_HOLD: begin
              label  = "sine_hold_ticks";
              shadow = 32'(sine_hold_q);
            end
            tdwg_pkg::REG_SQ_HIGH: begin
              label  = "square_high_level";
              shadow = 32'(sq_high_q);
            end
            tdwg_pkg::REG_SQ_LOW: begin
              label  = "square_low_level";
              shadow = 32'(sq_low_q);
            end
            default: begin
              label  = "triangle_step";
              shadow = 32'(tri_step_q);
            end
          endcase
          if (prdata !== shadow) begin
            $error("%s read: expected %0d, actual %0d", label, shadow, prdata);
            error_count++;
          end
        end
      end

      // tick requests
      if (in_valid_i && in_ready_o) begin
        if (advance_waveform(tick_i, predicted)) samples_due.push_back(predicted);
      end

      // sample requests
      if (out_valid_o && out_ready_i) begin
        if (samples_due.size() == 0) begin
          $error("dac_value: expected nothing, actual %0d", dac_value_o);
          error_count++;
        end else begin
          oldest = samples_due.pop_front();
          if (dac_value_o !== oldest) begin
            $error("dac_value: expected %0d, actual %0d", oldest, dac_value_o);
            error_count++;
          end
        end
      end
    end
    pending_o <= samples_due.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// top of the waveform generator testbench: clock, reset, stimulus and verdict
module testbench;

  // run limits
  localparam int CycleLimit  = 500_000;
  localparam int DrainCycles = 4;
  localparam int RandomTicks = 650;
  localparam int MaxIdle     = 17;

  // register port access kinds
  localparam logic CfgWrite = 1'b1;
  localparam logic CfgRead  = 1'b0;

  // addresses past the register map, writes there must be ignored
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        tick_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] dac_value_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  // when set, that side stops idling for the current stretch
  bit          src_gapless  = 1'b0;
  bit          sink_gapless = 1'b0;

  tick_driven_waveform_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .tick_i      (tick_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dac_value_o (dac_value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tdwg_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_i       (tick_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dac_value_o  (dac_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** tick_driven_waveform_generator: FAILED **");
      $finish;
    end
  end

  // sometimes sets junk above the register width, the block must drop it
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    if ($urandom_range(3, 0) == 0) return value | ($urandom() << width);
    return value;
  endfunction

  // counter limit: mostly short so results come often, now and then the extremes
  function automatic logic [31:0] draw_limit();
    case ($urandom_range(19, 0))
      17:      return 32'd255;
      18:      return 32'd0;
      19:      return 32'($urandom_range(255, 0));
      default: return ($urandom_range(16, 0) < 12) ? 32'($urandom_range(7, 0))
                                                   : 32'($urandom_range(60, 8));
    endcase
  endfunction

  // square level, with the rails drawn often
  function automatic logic [31:0] draw_level();
    case ($urandom_range(3, 0))
      0:       return 32'd0;
      1:       return 32'd4095;
      default: return 32'($urandom_range(4095, 0));
    endcase
  endfunction

  // setup phase, access phase held until pready, then a spare idle phase so back to back
  // accesses never drive psel twice in the same step
  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // read back every mapped register, the checker compares
  task automatic read_all_regs();
    for (int r = tdwg_pkg::REG_MODE; r <= tdwg_pkg::REG_TRI_STEP; r++) begin
      cfg_access(CfgRead, 3'(r), '0);
    end
  endtask

  // one tick request, after a random idle stretch (none while src_gapless is set)
  task automatic send_tick(input logic t);
    int gap;
    gap = src_gapless ? 0 : $urandom_range(MaxIdle, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid, wait for every expected sample, then let a tick that makes
  // no sample finish inside the block before the registers change
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input tdwg_pkg::wave_mode_e m);
    cfg_access(CfgWrite, tdwg_pkg::REG_MODE, with_junk(32'(m), 2));
  endtask

  // sample side: random stall before each sample request, none in gapless stretches
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_gapless ? 0 : $urandom_range(MaxIdle, 0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // stimulus and verdict
  initial begin
    int                   ticks_sent;
    int                   len;
    int                   phase;
    logic                 t;
    logic [31:0]          step;
    tdwg_pkg::wave_mode_e mode_sel;

    ticks_sent = 0;
    phase      = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----

    // reset values, then a zero tick and a tick that only counts
    read_all_regs();
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();

    // square toggling every tick between the rails, high level written with
    // all ones to see the width mask, zero tick in the middle
    cfg_access(CfgWrite, tdwg_pkg::REG_SQ_HIGH, 32'hFFFF_FFFF);
    cfg_access(CfgWrite, tdwg_pkg::REG_SQ_LOW, 32'd0);
    cfg_access(CfgWrite, tdwg_pkg::REG_SQ_HALF, 32'd0);
    set_mode(tdwg_pkg::MODE_SQUARE);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();

    // swap the levels without a mode write, phase carries on
    cfg_access(CfgWrite, tdwg_pkg::REG_SQ_LOW, 32'd4095);
    cfg_access(CfgWrite, tdwg_pkg::REG_SQ_HIGH, 32'hFFFF_F000);
    send_tick(1'b1);
    wait_idle();

    // sine with no hold, first entries of the table
    cfg_access(CfgWrite, tdwg_pkg::REG_SINE_HOLD, 32'd0);
    set_mode(tdwg_pkg::MODE_SINE);
    repeat (3) send_tick(1'b1);
    wait_idle();

    // triangle at the largest nominal step
    cfg_access(CfgWrite, tdwg_pkg::REG_TRI_STEP, 32'd40);
    set_mode(tdwg_pkg::MODE_TRIANGLE);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();

    // unused mode swallows ticks; writes past the map change nothing
    set_mode(tdwg_pkg::MODE_OFF);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_idle();
    cfg_access(CfgWrite, RegSpareLo, $urandom());
    cfg_access(CfgWrite, RegSpareHi, $urandom());
    send_tick(1'b1);
    wait_idle();
    read_all_regs();

    // ---- random part ----
    // each stretch draws new settings; a third of them keep the mode so the
    // waveform state runs on, which also lowers limits below a running count
    while (ticks_sent < RandomTicks) begin
      src_gapless  = ($urandom_range(3, 0) == 0);
      sink_gapless = ($urandom_range(3, 0) == 0);

      cfg_access(CfgWrite, tdwg_pkg::REG_SQ_HALF, with_junk(draw_limit(), 8));
      cfg_access(CfgWrite, tdwg_pkg::REG_SINE_HOLD, with_junk(draw_limit(), 8));
      cfg_access(CfgWrite, tdwg_pkg::REG_SQ_HIGH, with_junk(draw_level(), 12));
      cfg_access(CfgWrite, tdwg_pkg::REG_SQ_LOW, with_junk(draw_level(), 12));
      // step above 40 runs into saturation near the top of the ramp
      case ($urandom_range(7, 0))
        0:       step = 32'd0;
        1:       step = 32'd63;
        2:       step = 32'($urandom_range(63, 41));
        default: step = 32'($urandom_range(40, 0));
      endcase
      cfg_access(CfgWrite, tdwg_pkg::REG_TRI_STEP, with_junk(step, 6));

      if (phase == 0 || $urandom_range(2, 0) != 0) begin
        case ($urandom_range(9, 0))
          0, 1, 2: mode_sel = tdwg_pkg::MODE_SQUARE;
          3, 4, 5: mode_sel = tdwg_pkg::MODE_SINE;
          9:       mode_sel = tdwg_pkg::MODE_OFF;
          default: mode_sel = tdwg_pkg::MODE_TRIANGLE;
        endcase
        set_mode(mode_sel);
      end
      if ($urandom_range(5, 0) == 0) cfg_access(CfgWrite, RegSpareLo + 3'($urandom_range(1, 0)),
                                                $urandom());
      if ($urandom_range(3, 0) == 0) begin
        cfg_access(CfgRead, 3'($urandom_range(tdwg_pkg::REG_TRI_STEP, 0)), '0);
      end

      // long stretches let the sine table wrap and the triangle turn around
      len = ($urandom_range(3, 0) == 0) ? $urandom_range(260, 150) : $urandom_range(60, 15);
      if (len > RandomTicks - ticks_sent) len = RandomTicks - ticks_sent;
      repeat (len) begin
        t = ($urandom_range(9, 0) != 0);
        send_tick(t);
      end
      ticks_sent += len;
      wait_idle();
      phase++;
    end

    if (fail_count == 0) begin
      $display("** tick_driven_waveform_generator: PASSED **");
    end else begin
      $display("** tick_driven_waveform_generator: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tdwg_pkg.sv
hw/rtl/tick_driven_waveform_generator.sv
verif/tdwg_checker.sv
verif/testbench.sv
